// File: src/change_mask_row_delta_encoder_macros.svh
// assertion macros of the change-mask row delta encoder checker
`ifndef CHANGE_MASK_ROW_DELTA_ENCODER_MACROS_SVH
`define CHANGE_MASK_ROW_DELTA_ENCODER_MACROS_SVH

// consequent checked at the same edge as the antecedent
`define CMRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the edge after the antecedent
`define CMRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cmrd_pkg.sv
// shared constants and types of the change-mask row delta encoder
package cmrd_pkg;

  localparam int unsigned ROW_BYTES_DEF        = 32;
  localparam int unsigned SEGMENT_BYTES_DEF    = 256;
  localparam int unsigned MAX_SAMPLE_BYTES_DEF = 4096;

  // tag byte plus four mask bytes ahead of the changed bytes
  localparam int unsigned HEADER_LEN = 5;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned SAMPLE_W   = 13;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_SIZE_RST = 13'd4096;
  localparam logic [7:0]          TAG_BASE_RST    = 8'd32;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_SIZE = 1'b0;
  localparam logic REG_TAG_BASE    = 1'b1;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_CMP
  } front_state_e;

  typedef struct packed {
    logic [7:0]         tag;
    logic [MASK_W-1:0]  mask;
    logic [COUNT_W-1:0] count;
  } row_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic wr_slot;
    logic rd_slot;
  } fifo_stat_t;

endpackage

// File: src/change_mask_row_delta_encoder.sv
// top level of the change-mask row delta encoder
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  data_byte_i, frame_start_i
//   out      output     out_valid_o/out_ready_i out_byte_o, last_of_row_o
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata
//
// the front reads the reference store for each input byte, then compares and writes
// the back sends one coded byte a cycle unless stalled, at most HEADER_LEN + ROW_BYTES a row
// a two-row queue sits between them; the front stalls only while both row slots are full
// after reset a clearing pass zeroes all MAX_SAMPLE_BYTES entries of the reference store,
// no transaction on the input channel is taken meanwhile
module change_mask_row_delta_encoder import cmrd_pkg::*; #(
  parameter int unsigned ROW_BYTES        = ROW_BYTES_DEF,
  parameter int unsigned SEGMENT_BYTES    = SEGMENT_BYTES_DEF,
  parameter int unsigned MAX_SAMPLE_BYTES = MAX_SAMPLE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_row_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned PW = $clog2(MAX_SAMPLE_BYTES);
  localparam int unsigned BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  logic [SAMPLE_W-1:0] sample_size_q;
  logic [7:0]          tag_base_q;
  logic                cfg_we;

  fifo_stat_t    stat;
  row_desc_t     push_desc;
  row_desc_t     head_desc;
  logic          push;
  logic          pop;

  logic          ref_we;
  logic [PW-1:0] ref_waddr;
  logic [7:0]    ref_wdata;
  logic          ref_re;
  logic [PW-1:0] ref_raddr;
  logic [7:0]    ref_rdata;

  logic          buf_we;
  logic [BW:0]   buf_waddr;
  logic [7:0]    buf_wdata;
  logic          buf_re;
  logic [BW:0]   buf_raddr;
  logic [7:0]    buf_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_size_q <= SAMPLE_SIZE_RST;
      tag_base_q    <= TAG_BASE_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_SAMPLE_SIZE: sample_size_q <= pwdata[SAMPLE_W-1:0];
        REG_TAG_BASE:    tag_base_q    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SAMPLE_SIZE: prdata = 32'(sample_size_q);
      REG_TAG_BASE:    prdata = 32'(tag_base_q);
      default:         prdata = '0;
    endcase
  end

  cmrd_front #(
    .ROW_BYTES        (ROW_BYTES),
    .SEGMENT_BYTES    (SEGMENT_BYTES),
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .frame_start_i  (frame_start_i),
    .sample_size_i  (sample_size_q),
    .row_tag_base_i (tag_base_q),
    .stat_i         (stat),
    .push_o         (push),
    .desc_o         (push_desc),
    .ref_we_o       (ref_we),
    .ref_waddr_o    (ref_waddr),
    .ref_wdata_o    (ref_wdata),
    .ref_re_o       (ref_re),
    .ref_raddr_o    (ref_raddr),
    .ref_rdata_i    (ref_rdata),
    .buf_we_o       (buf_we),
    .buf_waddr_o    (buf_waddr),
    .buf_wdata_o    (buf_wdata)
  );

  cmrd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SAMPLE_BYTES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .re_i    (ref_re),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  // one row slot of changed bytes per queue entry
  cmrd_ram #(
    .WIDTH (8),
    .DEPTH (2 * (2 ** BW))
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  cmrd_row_fifo u_row_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .head_o (head_desc),
    .stat_o (stat)
  );

  cmrd_back #(
    .ROW_BYTES (ROW_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .stat_i        (stat),
    .pop_o         (pop),
    .buf_re_o      (buf_re),
    .buf_raddr_o   (buf_raddr),
    .buf_rdata_i   (buf_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_row_o (last_of_row_o)
  );

endmodule

// File: src/cmrd_ram.sv
// generic single-write, single-read ram with registered read data
module cmrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cmrd_front.sv
// front end: takes bytes, compares with the reference store, builds row masks
module cmrd_front import cmrd_pkg::*; #(
  parameter int unsigned ROW_BYTES        = ROW_BYTES_DEF,
  parameter int unsigned SEGMENT_BYTES    = SEGMENT_BYTES_DEF,
  parameter int unsigned MAX_SAMPLE_BYTES = MAX_SAMPLE_BYTES_DEF,
  localparam int unsigned PW = $clog2(MAX_SAMPLE_BYTES),
  localparam int unsigned BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  input  logic [SAMPLE_W-1:0] sample_size_i,
  input  logic [7:0]          row_tag_base_i,
  input  fifo_stat_t          stat_i,
  output logic                push_o,
  output row_desc_t           desc_o,
  output logic                ref_we_o,
  output logic [PW-1:0]       ref_waddr_o,
  output logic [7:0]          ref_wdata_o,
  output logic                ref_re_o,
  output logic [PW-1:0]       ref_raddr_o,
  input  logic [7:0]          ref_rdata_i,
  output logic                buf_we_o,
  output logic [BW:0]         buf_waddr_o,
  output logic [7:0]          buf_wdata_o
);

  localparam int unsigned RPS = (SEGMENT_BYTES / ROW_BYTES > 0) ?
                                SEGMENT_BYTES / ROW_BYTES : 1;
  localparam int unsigned RW  = (RPS > 1) ? $clog2(RPS) : 1;
  localparam int unsigned EW  = (PW + 1 > SAMPLE_W) ? PW + 1 : SAMPLE_W;

  front_state_e state_q, state_d;

  logic [PW-1:0]      clr_q, clr_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [BW-1:0]      bit_q, bit_d;
  logic [RW-1:0]      row_q, row_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         byte_q, byte_d;

  logic               accept;
  logic               diff;
  logic               row_end;
  logic [MASK_W-1:0]  mask_new;
  logic [COUNT_W-1:0] count_new;
  logic [PW:0]        pos_inc;
  logic [EW-1:0]      size_ext;
  logic [EW-1:0]      eff_size;

  assign accept  = (state_q == F_IDLE) && !stat_i.full && in_valid_i;
  assign diff    = (ref_rdata_i != byte_q);
  assign row_end = (bit_q == BW'(ROW_BYTES - 1));

  assign mask_new  = diff ? (mask_q | (MASK_W'(1) << bit_q)) : mask_q;
  assign count_new = count_q + COUNT_W'(diff);

  // zero behaves as one, anything above the store depth saturates
  assign size_ext = EW'(sample_size_i);
  assign eff_size = (size_ext == '0) ? EW'(1) :
                    (size_ext > EW'(MAX_SAMPLE_BYTES)) ? EW'(MAX_SAMPLE_BYTES) : size_ext;
  assign pos_inc  = {1'b0, pos_q} + (PW + 1)'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_CLEAR: begin
        if (clr_q == PW'(MAX_SAMPLE_BYTES - 1)) begin
          state_d = F_IDLE;
        end
      end
      F_IDLE: begin
        if (accept) begin
          state_d = F_CMP;
        end
      end
      F_CMP: begin
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    ref_we_o    = 1'b0;
    ref_waddr_o = pos_q;
    ref_wdata_o = byte_q;
    ref_re_o    = 1'b0;
    ref_raddr_o = frame_start_i ? '0 : pos_q;
    buf_we_o    = 1'b0;
    push_o      = 1'b0;
    case (state_q)
      F_CLEAR: begin
        ref_we_o    = 1'b1;
        ref_waddr_o = clr_q;
        ref_wdata_o = '0;
      end
      F_IDLE: begin
        in_ready_o = !stat_i.full;
        ref_re_o   = accept;
      end
      F_CMP: begin
        ref_we_o = diff;
        buf_we_o = diff;
        push_o   = row_end;
      end
      default: begin
      end
    endcase
  end

  assign buf_waddr_o = {stat_i.wr_slot, count_q[BW-1:0]};
  assign buf_wdata_o = byte_q;

  assign desc_o.tag   = row_tag_base_i + 8'(row_q);
  assign desc_o.mask  = mask_new;
  assign desc_o.count = count_new;

  always_comb begin
    clr_d   = clr_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    row_d   = row_q;
    mask_d  = mask_q;
    count_d = count_q;
    byte_d  = byte_q;
    if (state_q == F_CLEAR) begin
      clr_d = clr_q + PW'(1);
    end
    if (accept) begin
      byte_d = data_byte_i;
      // frame start drops any partial row
      if (frame_start_i) begin
        pos_d   = '0;
        bit_d   = '0;
        row_d   = '0;
        mask_d  = '0;
        count_d = '0;
      end
    end
    if (state_q == F_CMP) begin
      pos_d   = (EW'(pos_inc) >= eff_size) ? '0 : pos_inc[PW-1:0];
      mask_d  = mask_new;
      count_d = count_new;
      if (row_end) begin
        bit_d   = '0;
        mask_d  = '0;
        count_d = '0;
        row_d   = (row_q == RW'(RPS - 1)) ? '0 : row_q + RW'(1);
      end else begin
        bit_d = bit_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLEAR;
      clr_q   <= '0;
      pos_q   <= '0;
      bit_q   <= '0;
      row_q   <= '0;
      mask_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pos_q   <= pos_d;
      bit_q   <= bit_d;
      row_q   <= row_d;
      mask_q  <= mask_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// File: src/cmrd_row_fifo.sv
// two-entry queue of finished row descriptors between front and back
module cmrd_row_fifo import cmrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  row_desc_t  desc_i,
  input  logic       pop_i,
  output row_desc_t  head_o,
  output fifo_stat_t stat_o
);

  row_desc_t  entry_q [FIFO_DEPTH];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= desc_i;
    end
  end

  assign head_o         = entry_q[rd_q];
  assign stat_o.full    = (cnt_q == 2'(FIFO_DEPTH));
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.wr_slot = wr_q;
  assign stat_o.rd_slot = rd_q;

endmodule

// File: src/cmrd_back.sv
// back end: streams tag, mask bytes and changed bytes of each queued row
module cmrd_back import cmrd_pkg::*; #(
  parameter int unsigned ROW_BYTES = ROW_BYTES_DEF,
  localparam int unsigned BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  row_desc_t   head_i,
  input  fifo_stat_t  stat_i,
  output logic        pop_o,
  output logic        buf_re_o,
  output logic [BW:0] buf_raddr_o,
  input  logic [7:0]  buf_rdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_row_o
);

  localparam int unsigned KW = $clog2(ROW_BYTES + HEADER_LEN + 1);

  logic [KW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic          active;
  logic          can_load;
  logic          is_hdr;
  logic          load;
  logic          last;
  logic [KW-1:0] n_elem;
  logic [KW-1:0] k_after;
  logic [KW-1:0] data_idx;
  logic [1:0]    mb;
  logic [7:0]    hdr_byte;
  logic [7:0]    byte_nx;

  assign active   = !stat_i.empty;
  assign can_load = !out_valid_q || out_ready_i;
  assign n_elem   = KW'(HEADER_LEN) + KW'(head_i.count);
  assign is_hdr   = (k_q < KW'(HEADER_LEN));
  // data bytes load only once their ram read has come back
  assign load     = active && can_load && (is_hdr || pend_q);
  assign last     = (k_q == n_elem - KW'(1));
  assign k_after  = load ? (last ? '0 : k_q + KW'(1)) : k_q;
  assign data_idx = k_after - KW'(HEADER_LEN);

  // prefetch the next changed byte so the stream runs one byte a cycle while the output is not stalled
  assign buf_re_o    = active && (k_after >= KW'(HEADER_LEN)) && (k_after < n_elem) &&
                       (load || !pend_q);
  assign buf_raddr_o = {stat_i.rd_slot, data_idx[BW-1:0]};

  assign mb       = 2'(k_q - KW'(1));
  assign hdr_byte = (k_q == '0) ? head_i.tag : head_i.mask[{mb, 3'b000} +: 8];
  assign byte_nx  = is_hdr ? hdr_byte : buf_rdata_i;

  assign pop_o = load && last;

  always_comb begin
    k_d         = k_after;
    pend_d      = buf_re_o || (pend_q && !load);
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_nx;
      out_last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_row_o = out_last_q;

endmodule

// File: src/cmrd_checker.sv
// port-level checker for the change-mask row delta encoder, bound to the top level
`include "change_mask_row_delta_encoder_macros.svh"

module cmrd_checker import cmrd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [7:0]        out_byte_o,
  input logic              last_of_row_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  `CMRD_ASSERT_SAME(a_pready_high, clk_i, rst_ni, 1'b1, pready, "pready dropped")

  `CMRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(last_of_row_o), "stalled output transaction changed")

  `CMRD_ASSERT_SAME(a_clear_after_reset, clk_i, rst_ni, $rose(rst_ni), !in_ready_o, "input taken during reference store clearing")

  `CMRD_ASSERT_NEXT(a_two_cycle_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken in back-to-back cycles")

  `CMRD_ASSERT_SAME(a_tag_readback, clk_i, rst_ni, $past(rst_ni && psel && penable && pwrite && (paddr[2] == REG_TAG_BASE)) && (paddr[2] == REG_TAG_BASE), prdata[7:0] == $past(pwdata[7:0]), "row tag base readback mismatch")

endmodule

bind change_mask_row_delta_encoder cmrd_checker u_cmrd_checker (.*);

// File: verif/change_mask_row_delta_encoder_test.sv
// self-checking testbench of the change-mask row delta encoder
`timescale 1ns / 100ps

module change_mask_row_delta_encoder_test;
  import cmrd_pkg::*;

  localparam int ROWS_PER_SEG  = SEGMENT_BYTES_DEF / ROW_BYTES_DEF;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } coded_t;

  // one directed run: optional register write, then n bytes first, first+step, ...
  typedef struct {
    bit          cfg;
    logic        reg_sel;
    int          cfg_val;
    logic        fs;
    int          n;
    logic [7:0]  first;
    logic [7:0]  step;
    bit          typed;
    logic [7:0]  tag;
    logic [31:0] mask;
  } run_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              frame_start_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        out_byte_o;
  logic              last_of_row_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // encoder state as seen by the predictor
  logic [SAMPLE_W-1:0] cfg_sample_size;
  logic [7:0]          cfg_tag_base;
  logic [7:0]          last_seen [MAX_SAMPLE_BYTES_DEF];
  int                  samp_pos;
  int                  row_fill;
  int                  row_idx;
  logic [31:0]         row_mask;
  logic [7:0]          row_changes [$];
  bit                  quiet;

  coded_t coded_q [$];
  int     mismatches;
  int     in_idle_pct;
  int     stall_pct;

  run_t dir_runs [4] = '{
    '{0, REG_SAMPLE_SIZE, 0,  1, 32,  8'h00, 8'h00, 1, 8'd32, 32'h0000_0000},
    '{0, REG_SAMPLE_SIZE, 0,  0, 32,  8'hff, 8'h00, 1, 8'd33, 32'hffff_ffff},
    // six more rows close the segment, so the row index wraps to 0
    '{0, REG_SAMPLE_SIZE, 0,  0, 192, 8'h55, 8'h35, 0, 8'd0,  32'h0},
    // position left beyond a lowered sample size, first row of the next segment
    '{1, REG_SAMPLE_SIZE, 16, 0, 32,  8'h07, 8'h29, 0, 8'd0,  32'h0}
  };

  change_mask_row_delta_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_row_o (last_of_row_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_coded(input logic [7:0] value, input logic last);
    coded_t c;
    c.value = value;
    c.last  = last;
    coded_q.insert(coded_q.size(), c);
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic fs);
    int eff;
    int nchg;
    if (fs) begin
      samp_pos = 0;
      row_idx  = 0;
      row_fill = 0;
      row_mask = '0;
      row_changes.delete();
    end
    if (last_seen[samp_pos] != b) begin
      last_seen[samp_pos] = b;
      row_mask[row_fill] = 1'b1;
      row_changes.insert(row_changes.size(), b);
    end
    eff = (cfg_sample_size == 0) ? 1 :
          (cfg_sample_size > MAX_SAMPLE_BYTES_DEF) ? MAX_SAMPLE_BYTES_DEF : int'(cfg_sample_size);
    samp_pos = (samp_pos + 1 >= eff) ? 0 : samp_pos + 1;
    row_fill++;
    if (row_fill == ROW_BYTES_DEF) begin
      nchg = row_changes.size();
      if (!quiet) begin
        add_coded(8'(cfg_tag_base + row_idx), 1'b0);
        for (int i = 0; i < 4; i++)
          add_coded(row_mask[8*i +: 8], (i == 3 && nchg == 0));
        for (int i = 0; i < nchg; i++)
          add_coded(row_changes[i], (i == nchg - 1));
      end
      row_idx  = (row_idx + 1) % ROWS_PER_SEG;
      row_fill = 0;
      row_mask = '0;
      row_changes.delete();
    end
  endtask

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_byte(b, fs);
  endtask

  // wait for the block to drain before touching its registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic reg_sel, input int value);
    logic [31:0] keep;
    logic [31:0] word;
    keep = (reg_sel == REG_SAMPLE_SIZE) ? 32'h0000_1fff : 32'h0000_00ff;
    // junk above the register width must be ignored
    word = ($urandom() & ~keep) | (value & keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_sel == REG_SAMPLE_SIZE)
      cfg_sample_size = word[SAMPLE_W-1:0];
    else
      cfg_tag_base = word[7:0];
  endtask

  // one frame of whole rows plus an optional partial row, content partly repeating
  task automatic random_frame(input int rows, input int tail);
    int          keep_pct;
    logic        fs;
    logic [7:0]  b;
    keep_pct = $urandom_range(0, 100);
    for (int k = 0; k < rows * ROW_BYTES_DEF + tail; k++) begin
      fs = (k == 0);
      b  = ($urandom_range(99) < keep_pct) ? last_seen[fs ? 0 : samp_pos] : 8'($urandom());
      send_byte(b, fs);
    end
  endtask

  task automatic flag(input string what, input int want, input int got);
    $display("%0t: %s expected %h actual %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    coded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (coded_q.size() == 0) begin
        flag("unexpected transaction, out_byte", -1, out_byte_o);
      end else begin
        want = coded_q.pop_front();
        if (want.value !== out_byte_o) flag("out_byte", want.value, out_byte_o);
        if (want.last !== last_of_row_o) flag("last_of_row", want.last, last_of_row_o);
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    run_t r;
    int   nchg;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= '0;
    frame_start_i <= 1'b0;
    out_ready_i   <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cfg_sample_size = SAMPLE_SIZE_RST;
    cfg_tag_base    = TAG_BASE_RST;
    foreach (last_seen[i]) last_seen[i] = 8'h00;
    samp_pos    = 0;
    row_fill    = 0;
    row_idx     = 0;
    row_mask    = '0;
    quiet       = 1'b0;
    mismatches  = 0;
    in_idle_pct = 0;
    stall_pct   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_runs[j]) begin
      r = dir_runs[j];
      if (r.cfg) begin
        wait_idle();
        cfg_write(r.reg_sel, r.cfg_val);
      end
      if (r.typed) begin
        // whole row of one fill value: changed bytes are all the fill
        nchg = $countones(r.mask);
        add_coded(r.tag, 1'b0);
        for (int i = 0; i < 4; i++)
          add_coded(r.mask[8*i +: 8], (i == 3 && nchg == 0));
        for (int i = 0; i < nchg; i++)
          add_coded(r.first, (i == nchg - 1));
      end
      quiet = r.typed;
      for (int k = 0; k < r.n; k++)
        send_byte(8'(r.first + k * r.step), r.fs && k == 0);
      quiet = 1'b0;
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin in_idle_pct = 0;  stall_pct = 0;  end
        1: begin in_idle_pct = 79; stall_pct = 0;  end
        2: begin in_idle_pct = 0;  stall_pct = 79; end
        default: begin in_idle_pct = 37; stall_pct = 37; end
      endcase
      case (ph)
        0: cfg_write(REG_SAMPLE_SIZE, $urandom_range(4097, 8191));
        1: cfg_write(REG_SAMPLE_SIZE, $urandom_range(0, 2));
        2: cfg_write(REG_SAMPLE_SIZE, $urandom_range(3, 48));
        default: cfg_write(REG_SAMPLE_SIZE, $urandom_range(49, 400));
      endcase
      // a base near the top makes the tag wrap within the three-row frame
      cfg_write(REG_TAG_BASE, (ph == 2) ? $urandom_range(254, 255) : $urandom_range(0, 255));
      // partial row left pending, dropped by the next frame start
      random_frame((ph == 2) ? 3 : 1, (ph == 1) ? $urandom_range(1, ROW_BYTES_DEF - 1) : 0);
    end

    in_valid_i <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && coded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/cmrd_pkg.sv
src/cmrd_ram.sv
src/cmrd_front.sv
src/cmrd_row_fifo.sv
src/cmrd_back.sv
src/change_mask_row_delta_encoder.sv
src/cmrd_checker.sv
verif/change_mask_row_delta_encoder_test.sv
